>>> rtl/usc_pkg.sv
package usc_pkg;

   localparam int LenWidth = 13;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [LenWidth-1:0] MaxBudget = 13'd4096;
   localparam logic [LenWidth-1:0] MaxLengthReset = 13'd1024;

   localparam logic RegMaxLength = 1'b0;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] Lead2Low = 8'hC2;
   localparam logic [7:0] Lead2High = 8'hDF;
   localparam logic [7:0] Lead3Low = 8'hE0;
   localparam logic [7:0] Lead3High = 8'hEF;
   localparam logic [7:0] Lead4Low = 8'hF0;
   localparam logic [7:0] Lead4High = 8'hF4;
   localparam logic [7:0] ContLow = 8'h80;
   localparam logic [7:0] ContHigh = 8'hBF;
   localparam logic [7:0] ContMid = 8'hA0;
   localparam logic [7:0] LeadSurrogate = 8'hED;
   localparam logic [7:0] ContPlane = 8'h90;
   localparam logic [7:0] QuestionMark = 8'h3F;
   localparam logic [7:0] NulByte = 8'h00;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            term;
      logic            changed;
   } usc_bundle_type;

endpackage

>>> rtl/utf8_sanitizing_copy.sv
// channel   direction  ports
// req       in         req_valid, req_ready, req_in_byte, req_source_absent
// rsp       out        rsp_valid, rsp_ready, rsp_out_byte, rsp_is_terminator,
//                      rsp_changed, rsp_last
// csr       in/out     csr_psel, csr_penable, csr_pwrite, csr_paddr, csr_pwdata,
//                      csr_prdata, csr_pready
//
// one input transaction per cycle while the four-entry result queue has room
// each transaction yields zero to four results, sent one per cycle from the queue head while rsp_ready is high
// req_ready drops only when the result queue is full; rsp stalls back up into it
// synchronous reset clears string state and the queue, max_length returns to 1024
module utf8_sanitizing_copy (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_in_byte,
   input  logic                              req_source_absent,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_is_terminator,
   output logic                              rsp_changed,
   output logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [usc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [usc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [usc_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import usc_pkg::*;

   logic [LenWidth-1:0] max_length_ff, max_length_in;
   logic                csr_write;
   logic                accept;
   logic                push;
   usc_bundle_type      push_bundle;
   usc_bundle_type      head;
   logic                head_valid;
   logic                queue_full;
   logic                pop;

   always_comb begin
      csr_pready = 1'b1;
      csr_write = csr_psel && csr_penable && csr_pwrite &&
                  (csr_paddr[2] == RegMaxLength);
      max_length_in = csr_write ? csr_pwdata[LenWidth-1:0] : max_length_ff;
      csr_prdata = (csr_paddr[2] == RegMaxLength) ? CsrDataWidth'(max_length_ff) : '0;
      req_ready = !queue_full;
      accept = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MaxLengthReset;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   usc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .source_absent (req_source_absent),
      .max_length    (max_length_ff),
      .push          (push),
      .bundle        (push_bundle)
   );

   usc_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .not_empty   (head_valid),
      .full        (queue_full)
   );

   usc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .head_valid        (head_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_terminator (rsp_is_terminator),
      .rsp_changed       (rsp_changed),
      .rsp_last          (rsp_last),
      .pop               (pop)
   );

endmodule

>>> rtl/usc_front.sv
module usc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    in_byte,
   input  logic                          source_absent,
   input  logic [usc_pkg::LenWidth-1:0]  max_length,
   output logic                          push,
   output usc_pkg::usc_bundle_type       bundle
);
   import usc_pkg::*;

   logic [7:0]          lead_ff, lead_in;
   logic [1:0][7:0]     held_ff, held_in;
   logic [1:0]          hc_ff, hc_in;
   logic [2:0]          seqlen_ff, seqlen_in;
   logic [LenWidth-1:0] bw_ff, bw_in;
   logic                chg_ff, chg_in;
   logic                stop_ff, stop_in;

   logic [LenWidth-1:0] lim;
   logic [LenWidth-1:0] room_big;
   logic [2:0]          room4;
   logic [2:0]          lead_len;
   logic                cont_ok;
   logic [7:0]          final_byte;
   logic [2:0]          emit_k;
   logic                has_final;
   logic [2:0]          emit_n;
   logic                over;
   logic [3:0][7:0]     emit_bytes;
   logic                is_nul;

   always_comb begin
      lim = (max_length > MaxBudget) ? MaxBudget : max_length;
      room_big = (lim > bw_ff) ? (lim - bw_ff) : '0;
      room4 = (room_big >= 13'd4) ? 3'd4 : room_big[2:0];
      is_nul = (in_byte == NulByte);

      if (in_byte >= Lead2Low && in_byte <= Lead2High) begin
         lead_len = 3'd2;
      end else if (in_byte >= Lead3Low && in_byte <= Lead3High) begin
         lead_len = 3'd3;
      end else if (in_byte >= Lead4Low && in_byte <= Lead4High) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end

      cont_ok = (in_byte >= ContLow) && (in_byte <= ContHigh);
      if (hc_ff == 2'd0) begin
         if (lead_ff == Lead3Low && in_byte < ContMid) cont_ok = 1'b0;
         if (lead_ff == LeadSurrogate && in_byte >= ContMid) cont_ok = 1'b0;
         if (lead_ff == Lead4Low && in_byte < ContPlane) cont_ok = 1'b0;
         if (lead_ff == Lead4High && in_byte >= ContPlane) cont_ok = 1'b0;
      end

      final_byte = in_byte[7] ? QuestionMark : in_byte;
   end

   // how many single bytes this transaction tries to emit
   always_comb begin
      emit_k = 3'd0;
      has_final = 1'b0;
      if (!source_absent) begin
         if (is_nul) begin
            if (seqlen_ff != 3'd0) begin
               emit_k = {1'b0, hc_ff} + 3'd1;
            end
         end else if (!stop_ff) begin
            if (seqlen_ff == 3'd0) begin
               if (lead_len == 3'd0) begin
                  emit_k = 3'd1;
                  has_final = 1'b1;
               end
            end else if (!cont_ok) begin
               has_final = (lead_len == 3'd0);
               emit_k = {1'b0, hc_ff} + 3'd1 + {2'b0, has_final};
            end
         end
      end
      over = (emit_k > room4);
      emit_n = over ? room4 : emit_k;
      for (int i = 0; i < 4; i++) begin
         emit_bytes[i] = (has_final && (3'(i) == emit_k - 3'd1)) ? final_byte : QuestionMark;
      end
   end

   always_comb begin
      lead_in = lead_ff;
      held_in = held_ff;
      hc_in = hc_ff;
      seqlen_in = seqlen_ff;
      bw_in = bw_ff;
      chg_in = chg_ff;
      stop_in = stop_ff;
      bundle = '0;

      if (accept) begin
         if (source_absent) begin
            bundle.count = 3'd1;
            bundle.term = 1'b1;
            bundle.changed = 1'b1;
         end else if (is_nul) begin
            bundle.bytes = emit_bytes;
            bundle.bytes[emit_n[1:0]] = NulByte;
            bundle.count = emit_n + 3'd1;
            bundle.term = 1'b1;
            bundle.changed = chg_ff | (seqlen_ff != 3'd0);
         end else if (stop_ff) begin
            bundle = '0;
         end else if (seqlen_ff == 3'd0) begin
            if (lead_len != 3'd0) begin
               seqlen_in = lead_len;
               lead_in = in_byte;
               hc_in = 2'd0;
            end else begin
               bundle.bytes = emit_bytes;
               bundle.count = emit_n;
               chg_in = chg_ff | in_byte[7] | over;
               stop_in = over;
               bw_in = bw_ff + LenWidth'(emit_n);
            end
         end else if (!cont_ok) begin
            bundle.bytes = emit_bytes;
            bundle.count = emit_n;
            chg_in = 1'b1;
            stop_in = over;
            bw_in = bw_ff + LenWidth'(emit_n);
            hc_in = 2'd0;
            if (lead_len != 3'd0 && !over) begin
               seqlen_in = lead_len;
               lead_in = in_byte;
            end else begin
               seqlen_in = 3'd0;
            end
         end else if (({1'b0, hc_ff} + 3'd2) < seqlen_ff) begin
            held_in[hc_ff[0]] = in_byte;
            hc_in = hc_ff + 2'd1;
         end else begin
            if (room4 >= seqlen_ff) begin
               bundle.bytes[0] = lead_ff;
               bundle.bytes[1] = (hc_ff >= 2'd1) ? held_ff[0] : in_byte;
               bundle.bytes[2] = (hc_ff == 2'd2) ? held_ff[1] : in_byte;
               bundle.bytes[3] = in_byte;
               bundle.count = seqlen_ff;
               bw_in = bw_ff + LenWidth'(seqlen_ff);
            end else begin
               stop_in = 1'b1;
               chg_in = 1'b1;
            end
            hc_in = 2'd0;
            seqlen_in = 3'd0;
         end

         if (source_absent || is_nul) begin
            lead_in = '0;
            hc_in = 2'd0;
            seqlen_in = 3'd0;
            bw_in = '0;
            chg_in = 1'b0;
            stop_in = 1'b0;
         end
      end

      push = accept && (bundle.count != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= '0;
         hc_ff <= 2'd0;
         seqlen_ff <= 3'd0;
         bw_ff <= '0;
         chg_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else begin
         lead_ff <= lead_in;
         hc_ff <= hc_in;
         seqlen_ff <= seqlen_in;
         bw_ff <= bw_in;
         chg_ff <= chg_in;
         stop_ff <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

>>> rtl/usc_queue.sv
module usc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  usc_pkg::usc_bundle_type  push_bundle,
   input  logic                     pop,
   output usc_pkg::usc_bundle_type  head,
   output logic                     not_empty,
   output logic                     full
);
   import usc_pkg::*;

   usc_bundle_type [QueueDepth-1:0] entry_ff;
   logic [QueuePtrWidth-1:0]        wr_ff, wr_in;
   logic [QueuePtrWidth-1:0]        rd_ff, rd_in;
   logic [QueueCountWidth-1:0]      count_ff, count_in;

   always_comb begin
      full = (count_ff == QueueCountWidth'(QueueDepth));
      not_empty = (count_ff != '0);
      head = entry_ff[rd_ff];
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + QueueCountWidth'(push) - QueueCountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_bundle;
      end
   end

endmodule

>>> rtl/usc_back.sv
module usc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  usc_pkg::usc_bundle_type  head,
   input  logic                     head_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_is_terminator,
   output logic                     rsp_changed,
   output logic                     rsp_last,
   output logic                     pop
);
   import usc_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       at_end;
   logic       fire;

   always_comb begin
      at_end = ({1'b0, idx_ff} == (head.count - 3'd1));
      fire = head_valid && rsp_ready;
      pop = fire && at_end;
      rsp_valid = head_valid;
      rsp_out_byte = head.bytes[idx_ff];
      rsp_last = at_end;
      rsp_is_terminator = at_end && head.term;
      rsp_changed = at_end && head.term && head.changed;
      if (fire) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

>>> rtl/usc_checker.sv
module usc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [7:0]                        req_in_byte,
   input logic                              req_source_absent,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [7:0]                        rsp_out_byte,
   input logic                              rsp_is_terminator,
   input logic                              rsp_changed,
   input logic                              rsp_last,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [usc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input logic [usc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   input logic [usc_pkg::CsrDataWidth-1:0]  csr_prdata,
   input logic                              csr_pready
);
   import usc_pkg::*;

   // terminator always closes the transaction's results
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminator |-> rsp_last)
      else $error("terminator not marked last");

   // changed only rides on a terminator
   a_changed_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> rsp_is_terminator)
      else $error("changed set off terminator");

   // copied or replaced bytes are never zero, the terminator always is
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_byte == NulByte) == rsp_is_terminator))
      else $error("zero byte and terminator flag disagree");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind utf8_sanitizing_copy usc_checker u_checker (.*);

>>> tb/sv/usc_text_checker.sv
`timescale 1ns / 1ps

module usc_text_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_source_absent,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [7:0]                       rsp_out_byte,
   input  logic                             rsp_is_terminator,
   input  logic                             rsp_changed,
   input  logic                             rsp_last,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [usc_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [usc_pkg::CsrDataWidth-1:0] csr_pwdata,
   input  logic                             csr_pready,
   output int unsigned                      fail_count,
   output int unsigned                      outstanding
);
   import usc_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       term;
      logic       chg;
      logic       last;
   } text_result_type;

   text_result_type   pending_text[$];
   text_result_type   item_results[$];

   logic [LenWidth-1:0] max_length;
   logic [7:0]          lead;
   logic [7:0]          held[2];
   int unsigned         held_n;
   int unsigned         seq_len;
   int unsigned         written;
   bit                  change_seen;
   bit                  stopped;

   function automatic void clear_string();
      lead = '0;
      held[0] = '0;
      held[1] = '0;
      held_n = 0;
      seq_len = 0;
      written = 0;
      change_seen = 1'b0;
      stopped = 1'b0;
   endfunction

   function automatic void put_result(input logic [7:0] data, input logic term,
                                      input logic chg);
      text_result_type r;
      r = '{data, term, chg, 1'b0};
      if (item_results.size() < 4)
         item_results.insert(item_results.size(), r);
   endfunction

   function automatic int unsigned budget_room();
      int unsigned lim;
      lim = 32'((max_length > MaxBudget) ? MaxBudget : max_length);
      return (lim > written) ? lim - written : 0;
   endfunction

   function automatic void emit_one(input logic [7:0] b);
      if (stopped)
         return;
      if (budget_room() == 0) begin
         stopped = 1'b1;
         change_seen = 1'b1;
         return;
      end
      put_result(b, 1'b0, 1'b0);
      written++;
   endfunction

   function automatic void take_lead(input logic [7:0] b);
      if (stopped)
         return;
      if (b >= Lead2Low && b <= Lead2High) begin
         seq_len = 2;
      end else if (b >= Lead3Low && b <= Lead3High) begin
         seq_len = 3;
      end else if (b >= Lead4Low && b <= Lead4High) begin
         seq_len = 4;
      end else begin
         if (b >= ContLow) begin
            change_seen = 1'b1;
            emit_one(QuestionMark);
         end else begin
            emit_one(b);
         end
         return;
      end
      lead = b;
      held_n = 0;
   endfunction

   function automatic void fail_pending();
      change_seen = 1'b1;
      emit_one(QuestionMark);
      for (int unsigned i = 0; i < held_n && i < 2; i++)
         emit_one(QuestionMark);
      held_n = 0;
      seq_len = 0;
   endfunction

   function automatic bit cont_ok(input logic [7:0] b, input int unsigned pos);
      bit ok;
      ok = (b >= ContLow && b <= ContHigh);
      if (pos == 1) begin
         if (lead == Lead3Low && b < ContMid) ok = 1'b0;
         if (lead == LeadSurrogate && b >= ContMid) ok = 1'b0;
         if (lead == Lead4Low && b < ContPlane) ok = 1'b0;
         if (lead == Lead4High && b >= ContPlane) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic void take_cont(input logic [7:0] b);
      int unsigned pos;
      pos = held_n + 1;
      if (!cont_ok(b, pos)) begin
         fail_pending();
         take_lead(b);
         return;
      end
      if (pos + 1 < seq_len && held_n < 2) begin
         held[held_n] = b;
         held_n++;
         return;
      end
      if (budget_room() >= seq_len) begin
         put_result(lead, 1'b0, 1'b0);
         for (int unsigned i = 0; i < held_n && i < 2; i++)
            put_result(held[i], 1'b0, 1'b0);
         put_result(b, 1'b0, 1'b0);
         written += seq_len;
      end else begin
         stopped = 1'b1;
         change_seen = 1'b1;
      end
      held_n = 0;
      seq_len = 0;
   endfunction

   function automatic void sanitize_byte(input logic [7:0] b, input logic absent);
      item_results.delete();
      if (absent) begin
         put_result(NulByte, 1'b1, 1'b1);
         clear_string();
      end else if (b == NulByte) begin
         if (seq_len != 0)
            fail_pending();
         put_result(NulByte, 1'b1, change_seen);
         clear_string();
      end else if (!stopped) begin
         if (seq_len != 0)
            take_cont(b);
         else
            take_lead(b);
      end
      if (item_results.size() > 0)
         item_results[item_results.size() - 1].last = 1'b1;
      foreach (item_results[i])
         pending_text.insert(pending_text.size(), item_results[i]);
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      text_result_type want;
      if (reset) begin
         max_length = MaxLengthReset;
         clear_string();
         pending_text.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             (csr_paddr >> 2) == CsrAddrWidth'(RegMaxLength))
            max_length = csr_pwdata[LenWidth-1:0];
         if (req_valid && req_ready)
            sanitize_byte(req_in_byte, req_source_absent);
         if (rsp_valid && rsp_ready) begin
            if (pending_text.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual byte %0h term %0b",
                        $time, rsp_out_byte, rsp_is_terminator);
               fail_count++;
            end else begin
               want = pending_text.pop_front();
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("is_terminator", 8'(want.term), 8'(rsp_is_terminator));
               check_field("changed", 8'(want.chg), 8'(rsp_changed));
               check_field("last", 8'(want.last), 8'(rsp_last));
            end
         end
      end
      outstanding = pending_text.size();
   end

endmodule

>>> tb/sv/tb_utf8_sanitizing_copy.sv
`timescale 1ns / 1ps

module tb_utf8_sanitizing_copy;
   import usc_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned SettleCycles = 8;

   typedef enum int unsigned {StallNone, StallHalf, StallHeavy, StallLight} stall_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_in_byte = '0;
   logic                    req_source_absent = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [7:0]              rsp_out_byte;
   logic                    rsp_is_terminator;
   logic                    rsp_changed;
   logic                    rsp_last;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   int unsigned    fail_count;
   int unsigned    outstanding;
   int unsigned    cycle_count;
   int unsigned    burst_left;
   int unsigned    stall_span;
   stall_mode_type stall_mode;

   utf8_sanitizing_copy dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_source_absent (req_source_absent),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_terminator (rsp_is_terminator),
      .rsp_changed       (rsp_changed),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   usc_text_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_source_absent (req_source_absent),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_terminator (rsp_is_terminator),
      .rsp_changed       (rsp_changed),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver stalls in spans of varying density
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_span = $urandom_range(4, 40);
      end
      stall_span--;
      case (stall_mode)
         StallNone: begin
            rsp_ready <= 1'b1;
         end
         StallHalf: begin
            rsp_ready <= ($urandom_range(0, 1) == 0);
         end
         StallHeavy: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("utf8_sanitizing_copy verification failed");
      $finish;
   end

   task automatic send_item(input logic [7:0] value, input logic absent);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_in_byte <= value;
      req_source_absent <= absent;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   // hold off until every pending transaction has produced its results
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [LenWidth-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CsrAddrWidth'(RegMaxLength) << 2;
      csr_pwdata <= {(CsrDataWidth - LenWidth)'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic int unsigned make_utf8_sequence(output logic [7:0] seq[4]);
      int unsigned len;
      logic [7:0]  lo;
      logic [7:0]  hi;
      len = $urandom_range(2, 4);
      case (len)
         2: begin
            seq[0] = 8'($urandom_range(Lead2Low, Lead2High));
         end
         3: begin
            seq[0] = 8'($urandom_range(Lead3Low, Lead3High));
         end
         default: begin
            seq[0] = 8'($urandom_range(Lead4Low, Lead4High));
         end
      endcase
      lo = ContLow;
      hi = ContHigh;
      if (seq[0] == Lead3Low) lo = ContMid;
      else if (seq[0] == LeadSurrogate) hi = ContMid - 8'd1;
      else if (seq[0] == Lead4Low) lo = ContPlane;
      else if (seq[0] == Lead4High) hi = ContPlane - 8'd1;
      seq[1] = 8'($urandom_range(lo, hi));
      seq[2] = 8'($urandom_range(ContLow, ContHigh));
      seq[3] = 8'($urandom_range(ContLow, ContHigh));
      return len;
   endfunction

   task automatic send_random_text(input int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      int unsigned cut;
      logic [7:0]  seq[4];
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_item(8'($urandom_range(1, 127)), 1'b0);
            sent++;
         end else if (pick < 60) begin
            len = make_utf8_sequence(seq);
            for (int unsigned i = 0; i < len; i++)
               send_item(seq[i], 1'b0);
            sent += len;
         end else if (pick < 70) begin
            send_item(NulByte, 1'b0);
            sent++;
         end else if (pick < 74) begin
            send_item(8'($urandom()), 1'b1);
            sent++;
         end else if (pick < 85) begin
            // sequence broken off by an arbitrary byte
            len = make_utf8_sequence(seq);
            cut = $urandom_range(1, len - 1);
            for (int unsigned i = 0; i < cut; i++)
               send_item(seq[i], 1'b0);
            send_item(8'($urandom()), 1'b0);
            sent += cut + 1;
         end else begin
            send_item(8'($urandom()), 1'b0);
            sent++;
         end
      end
   endtask

   logic [8:0]          directed_items[25] = '{
      9'h041, 9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h0BF, 9'h0E0, 9'h09F, 9'h0ED,
      9'h0A0, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0F0, 9'h08F, 9'h0FF, 9'h0C1,
      9'h000, 9'h0E1, 9'h080, 9'h000, 9'h1A5, 9'h001, 9'h000
   };
   logic [LenWidth-1:0] budgets[8] = '{
      13'd0, 13'd3, 13'd8191, 13'd6, 13'd4096, 13'd1, 13'd12, 13'd1024
   };

   initial begin
      burst_left = 0;
      stall_span = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_items[i])
         send_item(directed_items[i][7:0], directed_items[i][8]);

      // strings are left open across budget changes on purpose
      foreach (budgets[i]) begin
         settle();
         write_max_length(budgets[i]);
         send_random_text(9);
      end

      settle();
      if (fail_count == 0) begin
         $display("utf8_sanitizing_copy verification clean");
      end else begin
         $display("utf8_sanitizing_copy verification failed");
      end
      $finish;
   end

endmodule
